[src/cmeg_pkg.sv]
// Shared types and constants for the cylinder mesh element generator.
// Used by the divider cell, the Horner cell and the top level.
package cmeg_pkg;

    typedef enum logic [3:0] {
        REQ_SIDE_VTX   = 4'd0,
        REQ_TOP_RIM    = 4'd1,
        REQ_BOT_RIM    = 4'd2,
        REQ_TOP_CTR    = 4'd3,
        REQ_BOT_CTR    = 4'd4,
        REQ_SIDE_TRI_A = 4'd5,
        REQ_SIDE_TRI_B = 4'd6,
        REQ_TOP_TRI    = 4'd7,
        REQ_BOT_TRI    = 4'd8
    } t_req;

    typedef enum logic [2:0] {
        CFG_TOP_RADIUS      = 3'd0,
        CFG_BOTTOM_RADIUS   = 3'd1,
        CFG_CYL_HEIGHT      = 3'd2,
        CFG_AXIAL_SEGMENTS  = 3'd3,
        CFG_HEIGHT_SEGMENTS = 3'd4,
        CFG_VERTEX_COLOR    = 3'd5
    } t_cfg_idx;

    localparam int QW    = 17;
    localparam int REM_W = 10;
    localparam int DIV_W = REM_W + QW;

    localparam logic [31:0] SIN_COEF [6] = '{
        32'd1686629713, 32'd693598668, 32'd85569306,
        32'd5026993, 32'd172272, 32'd3864
    };

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [QW-1:0]    word;
    } t_div;

    typedef struct packed {
        logic [31:0] acc;
        logic [30:0] u2;
        logic [30:0] u;
        logic        neg;
    } t_trig;

    typedef struct packed {
        logic signed [17:0] pos_x;
        logic signed [17:0] pos_y;
        logic signed [17:0] pos_z;
        logic [31:0]        color;
        logic [16:0]        index_a;
        logic [16:0]        index_b;
        logic [16:0]        index_c;
        logic               bad;
    } t_out;

    typedef struct packed {
        logic               valid;
        logic [3:0]         typ;
        logic               bad;
        logic               vtx;
        logic               center;
        logic [8:0]         ring;
        logic [8:0]         seg;
        logic [16:0]        ia;
        logic [16:0]        ib;
        logic [16:0]        ic;
        logic signed [26:0] rnum;
        logic [DIV_W-1:0]   ydiv;
        logic               yneg;
        logic               xneg;
        logic               zneg;
    } t_side;

endpackage

[src/cylinder_mesh_element_generator_unit.sv]
// Top level of the cylinder mesh element generator: decode, index math, phase and
// radius divider chains, sine/cosine Horner chains and a two-word output buffer.
// Depends on cmeg_pkg, cmeg_div_cell and cmeg_horner_cell.
//
//   channel   signals                         direction   word
//   request   i_valid / o_stall               in          req_type, ring, segment
//   result    o_valid / i_stall               out         position, color, indices, bad
//   config    i_cfg_valid / o_cfg_ready       in          index, data
//
// One word is accepted every cycle while o_stall is low; a result leaves after the
// 17-cell phase divider chain, the Horner chain and the 17-cell radius divider chain
// in series.
// Reset restores the register defaults and empties the chain.
// An output stall freezes the chain only once the two-word output buffer is full.
module cylinder_mesh_element_generator_unit #(
    parameter int MAX_AXIAL = 256,
    parameter int MAX_RINGS = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [3:0]         i_req_type,
    input  logic [8:0]         i_ring,
    input  logic [8:0]         i_segment,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [17:0] o_pos_x,
    output logic signed [17:0] o_pos_y,
    output logic signed [17:0] o_pos_z,
    output logic [31:0]        o_color_out,
    output logic [16:0]        o_index_a,
    output logic [16:0]        o_index_b,
    output logic [16:0]        o_index_c,
    output logic               o_bad_request,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import cmeg_pkg::*;

    localparam int LAT = 47;

    logic [15:0] r_top;
    logic [15:0] r_bot;
    logic [15:0] r_hgt;
    logic [8:0]  r_axial;
    logic [8:0]  r_hseg;
    logic [31:0] r_color;

    logic [8:0]  w_n;
    logic [8:0]  w_h;
    logic [9:0]  w_r;
    logic [16:0] w_tb;

    logic        w_adv;
    logic        w_push;
    logic        w_pop;

    t_side       w_s0;
    t_side       r_side [LAT];
    t_side       n_side [LAT];

    logic [24:0]        r1_mtop;
    logic signed [26:0] r1_mdiff;
    logic signed [26:0] r1_my;
    logic [18:0]        r1_mup;
    logic [DIV_W-1:0]   r1_pdiv;

    logic signed [16:0] w_diff;
    logic signed [10:0] w_yfac;
    logic signed [27:0] w_myfull;
    logic [16:0]        w_up;
    logic [16:0]        w_dn;
    logic [16:0]        w_bb;
    logic signed [26:0] w_rnum;

    t_div        w_pd [QW+1];
    t_div        w_xd [QW+1];
    t_div        w_zd [QW+1];
    t_div        w_yd [QW+1];

    t_trig       r19_sin;
    t_trig       r19_cos;
    t_trig       r20_sin;
    t_trig       r20_cos;
    t_trig       w_hs [6];
    t_trig       w_hc [6];
    logic [61:0] w_us2;
    logic [61:0] w_uc2;
    logic [62:0] w_fs;
    logic [62:0] w_fc;
    logic [30:0] r26_s;
    logic [30:0] r26_c;
    logic        r26_sneg;
    logic        r26_cneg;
    logic signed [15:0] r27_sin;
    logic signed [15:0] r27_cos;
    logic signed [42:0] r28_px;
    logic signed [42:0] r28_pz;
    logic [43:0]        w_ax;
    logic [43:0]        w_az;
    logic [DIV_W-1:0]   r29_xdiv;
    logic [DIV_W-1:0]   r29_zdiv;

    t_out        w_word;
    t_out        r_fifo [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;

    function automatic t_trig f_quad(input logic [15:0] p);
        t_trig       t;
        logic [14:0] a;
        a = p[14] ? 15'(15'd16384 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
        t.acc = '0;
        t.u2  = '0;
        t.u   = {a, 16'd0};
        t.neg = p[15];
        return t;
    endfunction

    function automatic logic signed [15:0] f_round(input logic [30:0] s, input logic neg);
        logic [31:0] sum;
        logic [15:0] v;
        sum = 32'(s) + 32'd32768;
        v   = sum[31:16];
        if (v > 16'd16384) begin
            v = 16'd16384;
        end
        return neg ? -$signed(v) : $signed(v);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= 16'd256;
            r_bot   <= 16'd256;
            r_hgt   <= 16'd512;
            r_axial <= 9'd16;
            r_hseg  <= 9'd1;
            r_color <= 32'hFFFF_FFFF;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TOP_RADIUS:      r_top   <= i_cfg_data[15:0];
                CFG_BOTTOM_RADIUS:   r_bot   <= i_cfg_data[15:0];
                CFG_CYL_HEIGHT:      r_hgt   <= i_cfg_data[15:0];
                CFG_AXIAL_SEGMENTS:  r_axial <= i_cfg_data[8:0];
                CFG_HEIGHT_SEGMENTS: r_hseg  <= i_cfg_data[8:0];
                CFG_VERTEX_COLOR:    r_color <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_n = r_axial;
        if (r_axial < 9'd3) begin
            w_n = 9'd3;
        end else if (int'(r_axial) > MAX_AXIAL) begin
            w_n = 9'(MAX_AXIAL);
        end
        w_h = r_hseg;
        if (r_hseg < 9'd1) begin
            w_h = 9'd1;
        end else if (int'(r_hseg) > MAX_RINGS) begin
            w_h = 9'(MAX_RINGS);
        end
        w_r  = {1'b0, w_n} + 10'd1;
        w_tb = 17'(({1'b0, w_h} + 10'd1) * w_r);
    end

    assign w_pop   = (r_cnt != 2'd0) && !i_stall;
    assign w_adv   = (r_cnt != 2'd2) || w_pop;
    assign o_stall = !w_adv;
    assign w_push  = w_adv && r_side[LAT-1].valid;

    always_comb begin
        w_s0        = '0;
        w_s0.valid  = i_valid;
        w_s0.typ    = i_req_type;
        w_s0.seg    = i_segment;
        w_s0.ring   = i_ring;
        unique case (i_req_type)
            REQ_SIDE_VTX: begin
                w_s0.bad = (i_ring > w_h) || (i_segment > w_n);
                w_s0.vtx = 1'b1;
            end
            REQ_TOP_RIM: begin
                w_s0.bad  = i_segment > w_n;
                w_s0.vtx  = 1'b1;
                w_s0.ring = '0;
            end
            REQ_BOT_RIM: begin
                w_s0.bad  = i_segment > w_n;
                w_s0.vtx  = 1'b1;
                w_s0.ring = w_h;
            end
            REQ_TOP_CTR: begin
                w_s0.vtx    = 1'b1;
                w_s0.center = 1'b1;
                w_s0.ring   = '0;
            end
            REQ_BOT_CTR: begin
                w_s0.vtx    = 1'b1;
                w_s0.center = 1'b1;
                w_s0.ring   = w_h;
            end
            REQ_SIDE_TRI_A, REQ_SIDE_TRI_B: begin
                w_s0.bad = (i_ring >= w_h) || (i_segment >= w_n);
            end
            REQ_TOP_TRI, REQ_BOT_TRI: begin
                w_s0.bad = i_segment >= w_n;
            end
            default: begin
                w_s0.bad = 1'b1;
            end
        endcase
    end

    always_comb begin
        w_diff   = $signed({1'b0, r_bot}) - $signed({1'b0, r_top});
        w_yfac   = $signed({2'b0, w_h}) - $signed({1'b0, r_side[0].ring, 1'b0});
        w_myfull = $signed({1'b0, r_hgt}) * w_yfac;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_mtop  <= r_top * w_h;
            r1_mdiff <= 27'(w_diff * $signed({1'b0, r_side[0].ring}));
            r1_my    <= w_myfull[26:0];
            r1_mup   <= r_side[0].ring * w_r;
            r1_pdiv  <= DIV_W'({r_side[0].seg, 16'd0}) + DIV_W'(w_n[8:1]);
        end
    end

    always_comb begin
        w_up   = 17'(r1_mup) + 17'(r_side[1].seg);
        w_dn   = w_up + 17'(w_r);
        w_bb   = w_tb + 17'(w_r) + 17'd1;
        w_rnum = $signed({2'b0, r1_mtop}) + r1_mdiff;
        for (int k = 0; k < LAT; k++) begin
            n_side[k] = (k == 0) ? w_s0 : r_side[(k == 0) ? 0 : k - 1];
        end
        n_side[2].rnum = w_rnum;
        n_side[2].yneg = r1_my < 0;
        n_side[2].ydiv = DIV_W'(r1_my < 0 ? -r1_my : r1_my) + DIV_W'(w_h);
        n_side[2].ia   = '0;
        n_side[2].ib   = '0;
        n_side[2].ic   = '0;
        unique case (r_side[1].typ)
            REQ_SIDE_TRI_A: begin
                n_side[2].ia = w_dn + 17'd1;
                n_side[2].ib = w_dn;
                n_side[2].ic = w_up;
            end
            REQ_SIDE_TRI_B: begin
                n_side[2].ia = w_up + 17'd1;
                n_side[2].ib = w_dn + 17'd1;
                n_side[2].ic = w_up;
            end
            REQ_TOP_TRI: begin
                n_side[2].ia = w_tb + 17'(w_r);
                n_side[2].ib = w_tb + 17'(r_side[1].seg) + 17'd1;
                n_side[2].ic = w_tb + 17'(r_side[1].seg);
            end
            REQ_BOT_TRI: begin
                n_side[2].ia = w_bb + 17'(w_r);
                n_side[2].ib = w_bb + 17'(r_side[1].seg);
                n_side[2].ic = w_bb + 17'(r_side[1].seg) + 17'd1;
            end
            default: ;
        endcase
        n_side[29].xneg = r28_px < 0;
        n_side[29].zneg = r28_pz < 0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_side[k].valid <= 1'b0;
            end
        end else if (w_adv) begin
            r_side <= n_side;
        end
    end

    assign w_pd[0] = '{rem: r1_pdiv[DIV_W-1:QW], word: r1_pdiv[QW-1:0]};

    for (genvar j = 0; j < QW; j++) begin : g_phase
        cmeg_div_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_div ({1'b0, w_n}),
            .i_d   (w_pd[j]),
            .o_d   (w_pd[j+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r19_sin <= f_quad(w_pd[QW].word[15:0]);
            r19_cos <= f_quad(w_pd[QW].word[15:0] + 16'd16384);
        end
    end

    always_comb begin
        w_us2        = 62'(r19_sin.u) * 62'(r19_sin.u);
        w_uc2        = 62'(r19_cos.u) * 62'(r19_cos.u);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r20_sin     <= '{acc: SIN_COEF[5], u2: w_us2[60:30], u: r19_sin.u,
                             neg: r19_sin.neg};
            r20_cos     <= '{acc: SIN_COEF[5], u2: w_uc2[60:30], u: r19_cos.u,
                             neg: r19_cos.neg};
        end
    end

    assign w_hs[0] = r20_sin;
    assign w_hc[0] = r20_cos;

    for (genvar j = 0; j < 5; j++) begin : g_horner
        cmeg_horner_cell #(.COEF(SIN_COEF[4-j])) u_sin (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_t   (w_hs[j]),
            .o_t   (w_hs[j+1])
        );
        cmeg_horner_cell #(.COEF(SIN_COEF[4-j])) u_cos (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_t   (w_hc[j]),
            .o_t   (w_hc[j+1])
        );
    end

    assign w_fs = 63'(w_hs[5].acc) * 63'(w_hs[5].u);
    assign w_fc = 63'(w_hc[5].acc) * 63'(w_hc[5].u);
    assign w_ax = 44'(r28_px < 0 ? -r28_px : r28_px) + 44'({w_h, 13'd0});
    assign w_az = 44'(r28_pz < 0 ? -r28_pz : r28_pz) + 44'({w_h, 13'd0});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r26_s    <= w_fs[60:30];
            r26_c    <= w_fc[60:30];
            r26_sneg <= w_hs[5].neg;
            r26_cneg <= w_hc[5].neg;
            r27_sin  <= f_round(r26_s, r26_sneg);
            r27_cos  <= f_round(r26_c, r26_cneg);
            r28_px   <= 43'(r_side[27].rnum * r27_cos);
            r28_pz   <= 43'(r_side[27].rnum * r27_sin);
            r29_xdiv <= w_ax[40:14];
            r29_zdiv <= w_az[40:14];
        end
    end

    assign w_xd[0] = '{rem: r29_xdiv[DIV_W-1:QW], word: r29_xdiv[QW-1:0]};
    assign w_zd[0] = '{rem: r29_zdiv[DIV_W-1:QW], word: r29_zdiv[QW-1:0]};
    assign w_yd[0] = '{rem: r_side[29].ydiv[DIV_W-1:QW], word: r_side[29].ydiv[QW-1:0]};

    for (genvar j = 0; j < QW; j++) begin : g_radius
        cmeg_div_cell u_x (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_div ({1'b0, w_h}),
            .i_d   (w_xd[j]),
            .o_d   (w_xd[j+1])
        );
        cmeg_div_cell u_z (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_div ({1'b0, w_h}),
            .i_d   (w_zd[j]),
            .o_d   (w_zd[j+1])
        );
        cmeg_div_cell u_y (
            .i_clk (i_clk),
            .i_en  (w_adv),
            .i_div ({w_h, 1'b0}),
            .i_d   (w_yd[j]),
            .o_d   (w_yd[j+1])
        );
    end

    always_comb begin
        w_word = '0;
        if (r_side[LAT-1].bad) begin
            w_word.bad = 1'b1;
        end else if (r_side[LAT-1].vtx) begin
            w_word.color = r_color;
            w_word.pos_y = r_side[LAT-1].yneg ? -$signed({1'b0, w_yd[QW].word})
                                              : $signed({1'b0, w_yd[QW].word});
            if (!r_side[LAT-1].center) begin
                w_word.pos_x = r_side[LAT-1].xneg ? -$signed({1'b0, w_xd[QW].word})
                                                  : $signed({1'b0, w_xd[QW].word});
                w_word.pos_z = r_side[LAT-1].zneg ? -$signed({1'b0, w_zd[QW].word})
                                                  : $signed({1'b0, w_zd[QW].word});
            end
        end else begin
            w_word.index_a = r_side[LAT-1].ia;
            w_word.index_b = r_side[LAT-1].ib;
            w_word.index_c = r_side[LAT-1].ic;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wp] <= w_word;
        end
    end

    assign o_valid       = r_cnt != 2'd0;
    assign o_pos_x       = r_fifo[r_rp].pos_x;
    assign o_pos_y       = r_fifo[r_rp].pos_y;
    assign o_pos_z       = r_fifo[r_rp].pos_z;
    assign o_color_out   = r_fifo[r_rp].color;
    assign o_index_a     = r_fifo[r_rp].index_a;
    assign o_index_b     = r_fifo[r_rp].index_b;
    assign o_index_c     = r_fifo[r_rp].index_c;
    assign o_bad_request = r_fifo[r_rp].bad;

endmodule

[src/cmeg_div_cell.sv]
// One restoring division step: shifts in a dividend bit and emits a quotient bit.
// Depends on cmeg_pkg for the cell word layout.
module cmeg_div_cell (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [cmeg_pkg::REM_W-1:0] i_div,
    input  cmeg_pkg::t_div            i_d,
    output cmeg_pkg::t_div            o_d
);
    import cmeg_pkg::*;

    logic [REM_W:0] w_t;
    logic           w_ge;
    t_div           n_d;
    t_div           r_d;

    always_comb begin
        w_t       = {i_d.rem, i_d.word[QW-1]};
        w_ge      = w_t >= {1'b0, i_div};
        n_d.rem   = w_ge ? REM_W'(w_t - {1'b0, i_div}) : w_t[REM_W-1:0];
        n_d.word  = {i_d.word[QW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

[src/cmeg_horner_cell.sv]
// One Horner step of the quarter-wave sine polynomial in Q30.
// Depends on cmeg_pkg for the lane word layout.
module cmeg_horner_cell #(
    parameter logic [31:0] COEF = 32'd0
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  cmeg_pkg::t_trig i_t,
    output cmeg_pkg::t_trig o_t
);
    import cmeg_pkg::*;

    logic [62:0] w_prod;
    t_trig       n_t;
    t_trig       r_t;

    always_comb begin
        w_prod    = 63'(i_t.acc) * 63'(i_t.u2);
        n_t       = i_t;
        n_t.acc   = COEF - w_prod[61:30];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t <= n_t;
        end
    end

    assign o_t = r_t;

endmodule

[src/cmeg_checker.sv]
// Port-level checks for the cylinder mesh element generator and their binding.
// Depends on the top level's port list only.
module cmeg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [17:0] o_pos_x,
    input logic signed [17:0] o_pos_y,
    input logic signed [17:0] o_pos_z,
    input logic [31:0]        o_color_out,
    input logic [16:0]        o_index_a,
    input logic [16:0]        o_index_b,
    input logic [16:0]        o_index_c,
    input logic               o_bad_request
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result word dropped while stalled");

    a_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_pos_x) && $stable(o_index_a)
            && $stable(o_bad_request))
        else $error("stalled result word changed");

    a_bad_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_request |-> o_pos_x == 0 && o_pos_y == 0 && o_pos_z == 0
            && o_color_out == 0 && o_index_a == 0 && o_index_b == 0 && o_index_c == 0)
        else $error("rejected request carries data");

    a_vertex_no_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_color_out != 0 |-> o_index_a == 0 && o_index_b == 0
            && o_index_c == 0)
        else $error("vertex word carries triangle indices");

endmodule

bind cylinder_mesh_element_generator_unit cmeg_checker u_cmeg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_pos_x       (o_pos_x),
    .o_pos_y       (o_pos_y),
    .o_pos_z       (o_pos_z),
    .o_color_out   (o_color_out),
    .o_index_a     (o_index_a),
    .o_index_b     (o_index_b),
    .o_index_c     (o_index_c),
    .o_bad_request (o_bad_request)
);
